// File: design/fht_pkg.sv
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types and constants for the failover history table.
// ----------------------------------------------------------------------------
package fht_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 6;

    typedef enum logic [2:0] {
        OP_CREATE    = 3'd0,
        OP_PRUNE     = 3'd1,
        OP_QUERY     = 3'd2,
        OP_ROLLBACK  = 3'd3,
        OP_LOAD_FRST = 3'd4,
        OP_LOAD_NEXT = 3'd5
    } fht_op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // issue read of scan index
        S_WAIT,    // read data returning
        S_EVAL,    // evaluate entry
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_FRONT,   // read front entry
        S_FRONT_WAIT,
        S_DONE
    } fht_state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [63:0]      wid;
        logic [63:0]      wseq;
        logic [IDX_W-1:0] raddr;
    } fht_mem_ctl_t;

endpackage

// File: design/fht_mem.sv
// ----------------------------------------------------------------------------
// fht_mem
// Entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fht_mem
    import fht_pkg::*;
(
    input  logic         clk,
    input  fht_mem_ctl_t ctl,
    output logic [63:0]  rid,
    output logic [63:0]  rseq
);

    logic [127:0] mem [TABLE_DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= {ctl.wid, ctl.wseq};
        end
        {rid, rseq} <= mem[ctl.raddr];
    end

endmodule

// File: design/failover_history_table_unit.sv
// ----------------------------------------------------------------------------
// failover_history_table_unit
// Ordered (newest first) history table with create, prune, query, rollback
// and load commands, run by a small sequencer over one table memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer.
//   Output channel (out_valid/out_stall) returns exactly one result per
//   command. Config channel (cfg_valid/cfg_ready) writes capacity_limit.
//   One command at a time: in_stall stays high from acceptance until its
//   result has been transferred. The sequencer walks the table memory
//   one entry at a time (read, read wait, evaluate); create and prune
//   compact in place during that scan, create then shifts entries down
//   by one (read, wait and write per moved entry). The next command can
//   be taken in the cycle after the result transfer. The memory read port
//   sets the pace.
//   Reset empties the table (count 0) and sets capacity_limit to 25; the
//   memory itself is not cleared. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module failover_history_table_unit
    import fht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [63:0] seqno,
    input  logic [63:0] uuid,
    input  logic [63:0] current_seqno,
    input  logic [63:0] snap_start,
    input  logic [63:0] snap_end,
    input  logic [63:0] purge_floor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        answer_flag,
    output logic [63:0] result_seqno,
    output logic [63:0] front_id,
    output logic [5:0]  entry_count,
    output logic [1:0]  status
);

    fht_state_t   state_reg, state_next;
    logic [5:0]   cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;       // read index
    logic [CNT_W-1:0] w_reg, w_next;       // write index / kept count
    logic [2:0]   op_reg;
    logic [63:0]  seq_reg, id_reg, ss_reg, se_reg, up_reg, purge_reg;
    logic         flag_reg, flag_next, found_reg, found_next;
    logic [63:0]  res_reg, res_next, prev_seq_reg, prev_seq_next, up_next;
    logic [63:0]  fid_reg, fid_next;
    logic [1:0]   st_reg, st_next;
    logic         ov_reg, ov_next;
    fht_mem_ctl_t mctl;
    logic [63:0]  rid, rseq;
    logic [5:0]   cap_eff;
    logic         accept;

    fht_mem u_mem (.clk(clk), .ctl(mctl), .rid(rid), .rseq(rseq));

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_valid    = ov_reg;
    assign answer_flag  = flag_reg;
    assign result_seqno = res_reg;
    assign front_id     = fid_reg;
    assign entry_count  = count_reg;
    assign status       = st_reg;

    // effective capacity
    always_comb
    begin
        if (cap_reg == 6'd0)
            cap_eff = 6'd1;
        else if (cap_reg > 6'(TABLE_DEPTH))
            cap_eff = 6'(TABLE_DEPTH);
        else
            cap_eff = cap_reg;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        w_next        = w_reg;
        flag_next     = flag_reg;
        found_next    = found_reg;
        res_next      = res_reg;
        prev_seq_next = prev_seq_reg;
        up_next       = up_reg;
        fid_next      = fid_reg;
        st_next       = st_reg;
        ov_next       = ov_reg;
        mctl.we       = 1'b0;
        mctl.waddr    = w_reg[IDX_W-1:0];
        mctl.wid      = rid;
        mctl.wseq     = rseq;
        mctl.raddr    = i_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    flag_next  = 1'b0;
                    res_next   = '0;
                    st_next    = ST_OK;
                    found_next = 1'b0;
                    i_next     = '0;
                    w_next     = '0;
                    up_next    = current_seqno;
                    state_next = S_FRONT;
                    case (opcode)
                        OP_CREATE, OP_PRUNE, OP_QUERY:
                        begin
                            state_next = (count_reg == '0) ? S_EVAL : S_RD;
                            if (opcode == OP_QUERY && count_reg == '0)
                                state_next = S_FRONT;
                        end
                        OP_ROLLBACK:
                        begin
                            if (seqno == 64'd0)
                                state_next = S_FRONT;
                            else
                            begin
                                // adjusted range checked in EVAL path
                                i_next     = count_reg;
                                state_next = (count_reg == '0) ? S_EVAL : S_RD;
                            end
                        end
                        OP_LOAD_FRST:
                        begin
                            mctl.we    = 1'b1;
                            mctl.waddr = '0;
                            mctl.wid   = uuid;
                            mctl.wseq  = seqno;
                            count_next = 6'd1;
                        end
                        OP_LOAD_NEXT:
                        begin
                            if (count_reg >= 6'(TABLE_DEPTH))
                                st_next = ST_FULL;
                            else
                            begin
                                mctl.we    = 1'b1;
                                mctl.waddr = count_reg[IDX_W-1:0];
                                mctl.wid   = uuid;
                                mctl.wseq  = seqno;
                                count_next = count_reg + 6'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (opcode == OP_ROLLBACK && seqno != 64'd0)
                    begin
                        mctl.raddr = IDX_W'(count_reg - 6'd1);
                    end
                end
            end
            S_RD:
            begin
                // rollback scans downward from count-1, others upward
                mctl.raddr = (op_reg == OP_ROLLBACK) ? IDX_W'(i_reg - 6'd1)
                                                     : i_reg[IDX_W-1:0];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // keep the address so the read data holds for evaluation
                mctl.raddr = (op_reg == OP_ROLLBACK) ? IDX_W'(i_reg - 6'd1)
                                                     : i_reg[IDX_W-1:0];
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_FRONT;
                case (op_reg)
                    OP_CREATE, OP_PRUNE:
                    begin
                        if (i_reg < count_reg)
                        begin
                            if (rseq <= seq_reg)
                            begin
                                mctl.we = (op_reg == OP_CREATE);
                                w_next  = w_reg + 6'd1;
                            end
                            i_next     = i_reg + 6'd1;
                            state_next = (i_reg + 6'd1 < count_reg) ? S_RD : S_EVAL;
                        end
                        else if (op_reg == OP_PRUNE && w_reg == '0)
                        begin
                            st_next = ST_REFUSED;
                        end
                        else if (op_reg == OP_PRUNE)
                        begin
                            // kept entries were compacted during the scan
                            count_next = w_reg;
                        end
                        else
                        begin
                            // create: trim, then shift down by one
                            count_next = (w_reg >= cap_eff) ? cap_eff - 6'd1 : w_reg;
                            i_next     = (w_reg >= cap_eff) ? cap_eff - 6'd1 : w_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (i_reg == '0)
                        begin
                            if (rid == id_reg)
                                state_next = S_FRONT;
                            else if (count_reg > 6'd1)
                            begin
                                prev_seq_next = rseq;
                                i_next        = 6'd1;
                                state_next    = S_RD;
                            end
                        end
                        else if (rid == id_reg)
                        begin
                            flag_next = 1'b1;
                            res_next  = prev_seq_reg;
                        end
                        else
                        begin
                            prev_seq_next = rseq;
                            i_next        = i_reg + 6'd1;
                            if (i_reg + 6'd1 < count_reg)
                                state_next = S_RD;
                        end
                    end
                    OP_ROLLBACK:
                    begin
                        if (ss_reg < purge_reg)
                        begin
                            flag_next = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            // rseq is the entry just newer than the match
                            if (i_reg != '0)
                                up_next = rseq;
                            state_next = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            flag_next = 1'b1;
                        end
                        else if (rid == id_reg)
                        begin
                            found_next = 1'b1;
                            i_next     = i_reg - 6'd1;
                            if (i_reg == 6'd1)
                                state_next = S_DONE;
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        else if (i_reg == 6'd1)
                        begin
                            flag_next = 1'b1;
                        end
                        else
                        begin
                            i_next     = i_reg - 6'd1;
                            state_next = S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT_RD:
            begin
                if (i_reg == '0)
                begin
                    mctl.we    = 1'b1;
                    mctl.waddr = '0;
                    mctl.wid   = id_reg;
                    mctl.wseq  = seq_reg;
                    count_next = count_reg + 6'd1;
                    state_next = S_FRONT;
                end
                else
                begin
                    mctl.raddr = IDX_W'(i_reg - 6'd1);
                    state_next = S_SHIFT_WAIT;
                end
            end
            S_SHIFT_WAIT:
            begin
                // hold the source address until the write
                mctl.raddr = IDX_W'(i_reg - 6'd1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mctl.we    = 1'b1;
                mctl.waddr = i_reg[IDX_W-1:0];
                i_next     = i_reg - 6'd1;
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                // upper-bound rule
                if (se_reg <= up_reg)
                    flag_next = 1'b0;
                else
                begin
                    flag_next = 1'b1;
                    res_next  = (up_reg < ss_reg) ? up_reg : ss_reg;
                end
                state_next = S_FRONT;
            end
            S_FRONT:
            begin
                mctl.raddr = '0;
                state_next = S_FRONT_WAIT;
            end
            S_FRONT_WAIT:
            begin
                if (!ov_reg)
                begin
                    fid_next   = (count_reg != '0) ? rid : 64'd0;
                    ov_next    = 1'b1;
                end
                else if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // compaction write for create and prune: write kept entry at w
        if (state_reg == S_EVAL && (op_reg == OP_CREATE || op_reg == OP_PRUNE)
            && i_reg < count_reg && rseq <= seq_reg)
        begin
            mctl.we    = 1'b1;
            mctl.waddr = w_reg[IDX_W-1:0];
            mctl.wid   = rid;
            mctl.wseq  = rseq;
        end
        // prune that is refused must not have written: writes at w<=i only
        // rewrite kept entries into earlier slots, and refusal means none kept
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= 6'd25;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        w_reg        <= w_next;
        flag_reg     <= flag_next;
        found_reg    <= found_next;
        res_reg      <= res_next;
        prev_seq_reg <= prev_seq_next;
        up_reg       <= up_next;
        fid_reg      <= fid_next;
        st_reg       <= st_next;
        if (accept)
        begin
            op_reg    <= opcode;
            seq_reg   <= seqno;
            id_reg    <= uuid;
            purge_reg <= purge_floor;
            ss_reg    <= (seqno == snap_end) ? seqno : snap_start;
            se_reg    <= (seqno != snap_end && seqno == snap_start) ? seqno : snap_end;
        end
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 6'(TABLE_DEPTH)) else $error("count overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open with result pending");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |=> $stable(count_reg))
        else $error("count changed while idle");

endmodule

// File: verif/tb_failover_history_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_failover_history_table_unit
// Self-checking bench for the failover history table. A behavioral table
// model predicts every result; results are compared field by field in order
// while both channels idle in random bursts, except late in the random test.
// ----------------------------------------------------------------------------
module tb_failover_history_table_unit;
    import fht_pkg::*;

    // Opcodes outside the package enum
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int         CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [63:0] seqno = '0, uuid = '0, current_seqno = '0;
    logic [63:0] snap_start = '0, snap_end = '0, purge_floor = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        answer_flag;
    logic [63:0] result_seqno, front_id;
    logic [5:0]  entry_count;
    logic [1:0]  status;

    typedef struct {
        logic        flag;
        logic [63:0] res;
        logic [63:0] front;
        logic [5:0]  cnt;
        logic [1:0]  st;
    } fht_result_t;

    fht_result_t expected_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int unsigned cycles = 0;
    bit          idle_on = 1'b1;

    // Model state
    logic [63:0] m_ids[TABLE_DEPTH];
    logic [63:0] m_seqs[TABLE_DEPTH];
    int          m_count = 0;
    int          m_cap = 25;

    // Recent ids used to build matching commands
    logic [63:0] pool_ids[$];

    failover_history_table_unit DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("failover_history_table_unit test failed");
            $finish;
        end
    end

    // Output stall bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        fht_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation pending");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (answer_flag !== e.flag)
                begin
                    $error("answer_flag exp %0h got %0h", e.flag, answer_flag);
                    errors++;
                end
                if (result_seqno !== e.res)
                begin
                    $error("result_seqno exp %0h got %0h", e.res, result_seqno);
                    errors++;
                end
                if (front_id !== e.front)
                begin
                    $error("front_id exp %0h got %0h", e.front, front_id);
                    errors++;
                end
                if (entry_count !== e.cnt)
                begin
                    $error("entry_count exp %0d got %0d", e.cnt, entry_count);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    // Remove entries above a seqno, keeping order
    function automatic void table_drop_newer(logic [63:0] lim);
        int w;
        w = 0;
        for (int i = 0; i < m_count; i++)
            if (m_seqs[i] <= lim)
            begin
                m_ids[w] = m_ids[i];
                m_seqs[w] = m_seqs[i];
                w++;
            end
        m_count = w;
    endfunction

    // Predict one command's result and update the model table
    function automatic fht_result_t table_predict(logic [2:0] op, logic [63:0] sq,
        logic [63:0] id, logic [63:0] cur, logic [63:0] ss_in, logic [63:0] se_in,
        logic [63:0] pg);
        fht_result_t r;
        int cap, kept, j;
        logic [63:0] upper, ss, se;
        bit found;
        r.flag = 1'b0;
        r.res = '0;
        r.st = ST_OK;
        case (op)
            OP_CREATE:
            begin
                table_drop_newer(sq);
                cap = (m_cap < 1) ? 1 : (m_cap > TABLE_DEPTH ? TABLE_DEPTH : m_cap);
                if (m_count >= cap) m_count = cap - 1;
                for (int i = m_count; i > 0; i--)
                begin
                    m_ids[i] = m_ids[i-1];
                    m_seqs[i] = m_seqs[i-1];
                end
                m_ids[0] = id;
                m_seqs[0] = sq;
                m_count++;
            end
            OP_PRUNE:
            begin
                kept = 0;
                for (int i = 0; i < m_count; i++) if (m_seqs[i] <= sq) kept++;
                if (kept == 0) r.st = ST_REFUSED;
                else table_drop_newer(sq);
            end
            OP_QUERY:
            begin
                if (m_count > 0 && m_ids[0] != id)
                    for (int i = 1; i < m_count; i++)
                        if (!r.flag && m_ids[i] == id)
                        begin
                            r.flag = 1'b1;
                            r.res = m_seqs[i-1];
                        end
            end
            OP_ROLLBACK:
            begin
                ss = ss_in;
                se = se_in;
                upper = cur;
                if (sq != 0)
                begin
                    if (sq == se) ss = sq;
                    else if (sq == ss) se = sq;
                    if (ss < pg) r.flag = 1'b1;
                    else
                    begin
                        found = 1'b0;
                        j = -1;
                        for (int i = m_count - 1; i >= 0; i--)
                            if (!found && m_ids[i] == id)
                            begin
                                found = 1'b1;
                                j = i;
                            end
                        if (found && j > 0) upper = m_seqs[j-1];
                        if (!found) r.flag = 1'b1;
                        else if (se > upper)
                        begin
                            r.flag = 1'b1;
                            r.res = (upper < ss) ? upper : ss;
                        end
                    end
                end
            end
            OP_LOAD_FRST:
            begin
                m_ids[0] = id;
                m_seqs[0] = sq;
                m_count = 1;
            end
            OP_LOAD_NEXT:
            begin
                if (m_count >= TABLE_DEPTH) r.st = ST_FULL;
                else
                begin
                    m_ids[m_count] = id;
                    m_seqs[m_count] = sq;
                    m_count++;
                end
            end
            default: ;
        endcase
        r.front = (m_count > 0) ? m_ids[0] : '0;
        r.cnt = m_count[5:0];
        return r;
    endfunction

    // Send one command, record its expectation at the transfer
    task automatic send_cmd(logic [2:0] op, logic [63:0] sq, logic [63:0] id,
        logic [63:0] cur, logic [63:0] ss, logic [63:0] se, logic [63:0] pg);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        opcode <= op;
        seqno <= sq;
        uuid <= id;
        current_seqno <= cur;
        snap_start <= ss;
        snap_end <= se;
        purge_floor <= pg;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.insert(expected_q.size(), table_predict(op, sq, id, cur, ss, se, pg));
        pool_ids.insert(pool_ids.size(), id);
        if (pool_ids.size() > 12) void'(pool_ids.pop_front());
        items_sent++;
        @(negedge clk);
    endtask

    // Wait until idle, then write capacity
    task automatic write_capacity(logic [5:0] v);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        m_cap = v;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_id();
        if (pool_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return pool_ids[$urandom_range(0, pool_ids.size() - 1)];
        return rand64();
    endfunction

    // Directed corners: empty table, extremes, every opcode
    task automatic test_directed();
        logic [63:0] mx, z;
        mx = '1;
        z = '0;
        send_cmd(OP_QUERY, z, z, z, z, z, z);
        send_cmd(OP_PRUNE, mx, z, z, z, z, z);
        send_cmd(OP_ROLLBACK, 64'd5, 64'd1, 64'd9, 64'd1, 64'd5, z);
        send_cmd(OP_ROLLBACK, z, 64'd1, 64'd9, 64'd1, 64'd5, z);
        send_cmd(OP_CREATE, 64'd10, 64'hA, z, z, z, z);
        send_cmd(OP_CREATE, 64'd20, 64'hB, z, z, z, z);
        send_cmd(OP_CREATE, mx, mx, z, z, z, z);
        send_cmd(OP_QUERY, z, 64'hA, z, z, z, z);
        send_cmd(OP_QUERY, z, mx, z, z, z, z);
        send_cmd(OP_ROLLBACK, 64'd15, 64'hA, 64'd30, 64'd15, 64'd25, z);
        send_cmd(OP_ROLLBACK, 64'd15, 64'hA, 64'd30, 64'd5, 64'd15, z);
        send_cmd(OP_ROLLBACK, 64'd15, 64'hA, 64'd30, 64'd15, 64'd25, 64'd16);
        send_cmd(OP_ROLLBACK, mx, mx, mx, mx, mx, z);
        send_cmd(OP_PRUNE, 64'd5, z, z, z, z, z);
        send_cmd(OP_PRUNE, 64'd15, z, z, z, z, z);
        send_cmd(OP_CREATE, 64'd5, 64'hC, z, z, z, z);
        send_cmd(OP_SPARE6, mx, mx, mx, mx, mx, mx);
        send_cmd(OP_SPARE7, z, z, z, z, z, z);
        send_cmd(OP_LOAD_FRST, mx, mx, z, z, z, z);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_cmd(OP_LOAD_NEXT, mx - 64'(i) - 64'd1, 64'(i), z, z, z, z);
        send_cmd(OP_QUERY, z, 64'd3, z, z, z, z);
    endtask

    // Capacity extremes, creates past each limit
    task automatic test_capacity();
        logic [5:0] caps[6] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd2, 6'd25};
        foreach (caps[k])
        begin
            write_capacity(caps[k]);
            for (int i = 0; i < 36; i++)
                send_cmd(OP_CREATE, 64'd1000 + 64'(i), rand64(), 64'd0, 64'd0, 64'd0,
                         64'd0);
        end
    endtask

    // Random mix weighted toward meaningful sequences
    task automatic test_random(int n);
        logic [63:0] base, sq, ss, se;
        int op;
        base = 100;
        for (int i = 0; i < n; i++)
        begin
            if (i == n - n / 8) idle_on = 1'b0;
            if (i % 500 == 250) write_capacity(6'($urandom_range(0, 63)));
            op = $urandom_range(0, 19);
            sq = ($urandom_range(0, 9) == 0) ? rand64() : base - $urandom_range(0, 40);
            ss = base - $urandom_range(0, 60);
            se = ss + $urandom_range(0, 60);
            if ($urandom_range(0, 3) == 0) sq = ss;
            else if ($urandom_range(0, 3) == 0) sq = se;
            if (op < 7)
            begin
                base = base + $urandom_range(1, 20);
                send_cmd(OP_CREATE, base, pick_id(), 64'd0, 64'd0, 64'd0, 64'd0);
            end
            else if (op < 9)
                send_cmd(OP_PRUNE, sq, rand64(), 64'd0, 64'd0, 64'd0, 64'd0);
            else if (op < 12)
                send_cmd(OP_QUERY, rand64(), pick_id(), 64'd0, 64'd0, 64'd0, 64'd0);
            else if (op < 16)
                send_cmd(OP_ROLLBACK, sq, pick_id(),
                         ($urandom_range(0, 7) == 0) ? rand64() : base, ss, se,
                         ($urandom_range(0, 2) == 0) ? base - $urandom_range(0, 80)
                                                     : 64'd0);
            else if (op == 16)
                send_cmd(OP_LOAD_FRST, rand64(), rand64(), 64'd0, 64'd0, 64'd0, 64'd0);
            else if (op < 19)
                send_cmd(OP_LOAD_NEXT, rand64(), pick_id(), 64'd0, 64'd0, 64'd0, 64'd0);
            else
                send_cmd(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(),
                         rand64(), rand64(), rand64());
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_capacity();
        test_random(1750);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
        $display("Covered %0d commands and %0d results over all opcodes,", items_sent,
                 results_seen);
        $display("capacity extremes, full-table loads and refused prunes.");
        if (errors == 0 && expected_q.size() == 0)
            $display("failover_history_table_unit test passed");
        else
            $display("failover_history_table_unit test failed");
        $finish;
    end

endmodule

// File: filelist.f
design/fht_pkg.sv
design/fht_mem.sv
design/failover_history_table_unit.sv
verif/tb_failover_history_table_unit.sv
